FILE: src/bmpsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpsd_pkg: shared types and constants of the BMP stream decoder
// Holds the result code set, the decoder phase type, the result record and
// the header constants used by the decoder core and the output buffer.
// ----------------------------------------------------------------------------
package bmpsd_pkg;

	// Header layout: 54 bytes of file and info header, the last at position 53.
	localparam logic [31:0] HDR_LEN  = 32'd54;
	localparam logic [31:0] HDR_LAST = 32'd53;

	// Signature characters and the supported depths.
	localparam logic [7:0]  SIG_B    = 8'h42;
	localparam logic [7:0]  SIG_M    = 8'h4D;
	localparam logic [15:0] DEPTH_24 = 16'd24;
	localparam logic [15:0] DEPTH_32 = 16'd32;

	// Header byte positions that are kept.
	localparam logic [5:0] POS_SIG0   = 6'd0;
	localparam logic [5:0] POS_SIG1   = 6'd1;
	localparam logic [5:0] POS_SIZE   = 6'd2;
	localparam logic [5:0] POS_RSV    = 6'd6;
	localparam logic [5:0] POS_OFFSET = 6'd10;
	localparam logic [5:0] POS_WIDTH  = 6'd18;
	localparam logic [5:0] POS_HEIGHT = 6'd22;
	localparam logic [5:0] POS_DEPTH  = 6'd28;

	typedef enum logic [2:0] {
		ST_PIXEL     = 3'd0,
		ST_HEADER_OK = 3'd1,
		ST_BAD_SIG   = 3'd2,
		ST_RESERVED  = 3'd3,
		ST_DEPTH     = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_DATA   = 4'b0100,
		PH_IDLE   = 4'b1000
	} phase_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [31:0] image_width;
		logic [31:0] image_height;
	} result_t;

endpackage

FILE: src/bmpsd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpsd_core: header capture, header check and pixel unpacking
// Updates the parse state for each accepted byte and presents the result,
// if the byte causes one, in the same cycle.
// ----------------------------------------------------------------------------
module bmpsd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          byte_value,
	input  logic                end_of_file,
	output logic                res_valid,
	output bmpsd_pkg::result_t  res
);
	import bmpsd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] pos_q, pos_next;
	logic [31:0] remain_q, remain_d;
	logic        bpp4_q, bpp4_d;
	logic [31:0] row_width_q, row_width_d;
	logic [1:0]  pix_idx_q, pix_idx_d;
	logic [31:0] col_q, col_d, col_inc;
	logic [1:0]  pad_left_q, pad_left_d;
	logic [7:0]  held_blue_q, held_blue_d;
	logic [7:0]  held_green_q, held_green_d;

	// Captured header fields.
	logic [7:0]  sig0_q, sig1_q;
	logic [31:0] size_q, rsv_q, offset_q, width_q, height_q;
	logic [15:0] depth_q;

	logic        pix_last;

	assign pos_next = pos_q + 32'd1;
	assign col_inc  = col_q + 32'd1;
	assign pix_last = bpp4_q ? (pix_idx_q == 2'd3) : (pix_idx_q >= 2'd2);

	always_comb begin
		phase_d      = phase_q;
		remain_d     = remain_q;
		bpp4_d       = bpp4_q;
		row_width_d  = row_width_q;
		pix_idx_d    = pix_idx_q;
		col_d        = col_q;
		pad_left_d   = pad_left_q;
		held_blue_d  = held_blue_q;
		held_green_d = held_green_q;
		res_valid    = 1'b0;
		res          = '0;

		unique case (phase_q)
			PH_HEADER: begin
				if (pos_q == HDR_LAST) begin
					res_valid = 1'b1;
					phase_d   = PH_IDLE;
					if (sig0_q != SIG_B || sig1_q != SIG_M) begin
						res.status = ST_BAD_SIG;
					end else if (rsv_q != 32'd0) begin
						res.status = ST_RESERVED;
					end else if (depth_q != DEPTH_24 && depth_q != DEPTH_32) begin
						res.status = ST_DEPTH;
					end else if (offset_q >= size_q) begin
						res.status = ST_EMPTY;
					end else begin
						res.status       = ST_HEADER_OK;
						res.image_width  = width_q;
						res.image_height = height_q;
						remain_d         = size_q - offset_q;
						bpp4_d           = (depth_q == DEPTH_32);
						row_width_d      = width_q;
						phase_d          = (offset_q <= HDR_LEN) ? PH_DATA : PH_SKIP;
					end
				end else if (pos_q > HDR_LAST) begin
					phase_d = PH_IDLE;
				end
			end
			PH_SKIP: begin
				if (pos_next >= offset_q) begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (remain_q == 32'd0) begin
					phase_d = PH_IDLE;
				end else begin
					remain_d = remain_q - 32'd1;
					if (pad_left_q != 2'd0) begin
						pad_left_d = pad_left_q - 2'd1;
					end else begin
						unique case (pix_idx_q)
							2'd0: begin
								held_blue_d = byte_value;
							end
							2'd1: begin
								held_green_d = byte_value;
							end
							2'd2: begin
								res_valid  = 1'b1;
								res.status = ST_PIXEL;
								res.red    = byte_value;
								res.green  = held_green_q;
								res.blue   = held_blue_q;
							end
							2'd3: begin
							end
						endcase
						if (pix_last) begin
							pix_idx_d = 2'd0;
							if (col_inc == row_width_q) begin
								col_d = 32'd0;
								// For three bytes a pixel the pad equals width mod 4.
								pad_left_d = bpp4_q ? 2'd0 : row_width_q[1:0];
							end else begin
								col_d = col_inc;
							end
						end else begin
							pix_idx_d = pix_idx_q + 2'd1;
						end
					end
					if (remain_q == 32'd1) begin
						phase_d = PH_IDLE;
					end
				end
			end
			PH_IDLE: begin
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= '0;
			remain_q    <= '0;
			bpp4_q      <= 1'b0;
			row_width_q <= '0;
			pix_idx_q   <= '0;
			col_q       <= '0;
			pad_left_q  <= '0;
		end else if (accept) begin
			if (end_of_file) begin
				phase_q     <= PH_HEADER;
				pos_q       <= '0;
				remain_q    <= '0;
				bpp4_q      <= 1'b0;
				row_width_q <= '0;
				pix_idx_q   <= '0;
				col_q       <= '0;
				pad_left_q  <= '0;
			end else begin
				phase_q     <= phase_d;
				pos_q       <= pos_next;
				remain_q    <= remain_d;
				bpp4_q      <= bpp4_d;
				row_width_q <= row_width_d;
				pix_idx_q   <= pix_idx_d;
				col_q       <= col_d;
				pad_left_q  <= pad_left_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_blue_q  <= held_blue_d;
			held_green_q <= held_green_d;
			if (phase_q == PH_HEADER && pos_q[31:6] == 26'd0) begin
				unique case (pos_q[5:0])
					POS_SIG0:          sig0_q          <= byte_value;
					POS_SIG1:          sig1_q          <= byte_value;
					POS_SIZE:          size_q[7:0]     <= byte_value;
					POS_SIZE + 6'd1:   size_q[15:8]    <= byte_value;
					POS_SIZE + 6'd2:   size_q[23:16]   <= byte_value;
					POS_SIZE + 6'd3:   size_q[31:24]   <= byte_value;
					POS_RSV:           rsv_q[7:0]      <= byte_value;
					POS_RSV + 6'd1:    rsv_q[15:8]     <= byte_value;
					POS_RSV + 6'd2:    rsv_q[23:16]    <= byte_value;
					POS_RSV + 6'd3:    rsv_q[31:24]    <= byte_value;
					POS_OFFSET:        offset_q[7:0]   <= byte_value;
					POS_OFFSET + 6'd1: offset_q[15:8]  <= byte_value;
					POS_OFFSET + 6'd2: offset_q[23:16] <= byte_value;
					POS_OFFSET + 6'd3: offset_q[31:24] <= byte_value;
					POS_WIDTH:         width_q[7:0]    <= byte_value;
					POS_WIDTH + 6'd1:  width_q[15:8]   <= byte_value;
					POS_WIDTH + 6'd2:  width_q[23:16]  <= byte_value;
					POS_WIDTH + 6'd3:  width_q[31:24]  <= byte_value;
					POS_HEIGHT:        height_q[7:0]   <= byte_value;
					POS_HEIGHT + 6'd1: height_q[15:8]  <= byte_value;
					POS_HEIGHT + 6'd2: height_q[23:16] <= byte_value;
					POS_HEIGHT + 6'd3: height_q[31:24] <= byte_value;
					POS_DEPTH:         depth_q[7:0]    <= byte_value;
					POS_DEPTH + 6'd1:  depth_q[15:8]   <= byte_value;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

FILE: src/bmpsd_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpsd_skid: two-entry result buffer
// An output register backed by one skid entry, so the input side keeps
// flowing after the output side stalls until a second result is queued.
// ----------------------------------------------------------------------------
module bmpsd_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bmpsd_pkg::result_t  push_data,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output bmpsd_pkg::result_t  out_data
);
	import bmpsd_pkg::*;

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    pop;

	assign pop       = out_valid_q && out_ready;
	assign room      = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

endmodule

FILE: src/bmp_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_decoder: streaming decoder for 24- and 32-bit BMP files
// Takes a file one byte per word, checks the 54-byte header, skips to the
// pixel data, emits a header result and one red/green/blue triple per pixel.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Word contents
// s_*      in         tdata[7:0] byte_value, tlast end_of_file
// m_*      out        tuser[2:0] status, tdata red, green, blue, width, height
//
// The parse state is updated at the edge that accepts each word, and any
// result goes into the output register, or into the one skid entry behind
// it if that register holds a stalled result. A new word can be accepted in
// every cycle while that entry is free; s_tready drops only while it is
// occupied, i.e. while a stalled result has a second one queued behind it.
// Reset (arst_n low) returns the decoder to the start of a header and empties
// the output buffer. A word with tlast high is processed normally and then
// restarts header parsing for the next file.
//
module bmp_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// Input byte stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tlast,   // end_of_file
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] red, [15:8] green, [23:16] blue, [55:24] image_width,
	// [87:56] image_height
	output logic [87:0] m_tdata,
	output logic [2:0]  m_tuser    // [2:0] status
);
	import bmpsd_pkg::*;

	logic    accept;
	logic    res_valid;
	result_t res;
	result_t out_res;
	logic    room;

	// A word is taken whenever the skid entry is free.
	assign s_tready = room;
	assign accept   = s_tvalid && room;

	// The parse state machine: header capture and check, offset skip and
	// pixel unpacking with row padding.
	bmpsd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.byte_value  (s_tdata),
		.end_of_file (s_tlast),
		.res_valid   (res_valid),
		.res         (res)
	);

	// The output register and its skid entry decouple the two sides.
	bmpsd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_data (res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	// The word layout places the colour bytes lowest and the header
	// dimensions above them; the result kind travels on tuser.
	assign m_tdata = {out_res.image_height, out_res.image_width,
		out_res.blue, out_res.green, out_res.red};
	assign m_tuser = out_res.status;

endmodule
